// ===== hw/rtl/apt_pkg.sv =====
// Shared types, constants and helpers for the averaging-period tachometer.
// Used by the channel interfaces, the controller, the datapath and the top level.
package apt_pkg;

   localparam int CfgWidth   = 32;
   localparam int CsrIdxW    = 2;
   localparam int CountW     = 9;
   localparam int TimerW     = 32;
   localparam int ConfSmallW = 8;
   localparam int NumW       = 48;
   localparam int DenW       = 40;
   localparam int RevW       = 40;
   localparam int RateW      = 36;
   localparam int MultW      = 16;
   localparam int ProdW      = RevW + MultW;
   localparam int QShift     = 20;
   localparam int UnitW      = 2;
   localparam int DivSteps   = RevW;
   localparam int DivCntW    = $clog2(DivSteps);

   localparam logic [NumW-1:0] MicroScale = 48'd1000000000000;
   localparam logic [RevW-1:0] RevMax     = {RevW{1'b1}};

   localparam logic [ConfSmallW-1:0] EdgesAvgReset = 8'd25;
   localparam logic [ConfSmallW-1:0] SlitsReset    = 8'd25;
   localparam logic [TimerW-1:0]     TimeoutReset  = 32'd4000000;
   localparam logic [TimerW-1:0]     BlankReset    = 32'd20000000;

   localparam logic [MultW-1:0] MultRpm   = 16'd62915;
   localparam logic [MultW-1:0] MultRevps = 16'd1049;
   localparam logic [MultW-1:0] MultRadps = 16'd6588;

   localparam logic [CsrIdxW-1:0] CSR_EDGES_AVG = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_SLITS     = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_TIMEOUT   = 2'd2;
   localparam logic [CsrIdxW-1:0] CSR_BLANK     = 2'd3;

   localparam logic [UnitW-1:0] UNIT_RPM   = 2'd0;
   localparam logic [UnitW-1:0] UNIT_REVPS = 2'd1;
   localparam logic [UnitW-1:0] UNIT_RADPS = 2'd2;

   localparam logic [7:0] UNIT_CODE_REVPS = 8'd1;
   localparam logic [7:0] UNIT_CODE_RADPS = 8'd2;

   typedef struct packed {
      logic tick;
      logic ops_load;
      logic div_init;
      logic div_step;
      logic rev_store;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic fresh;
      logic out_free;
   } status_type;

   function automatic logic [MultW-1:0] unit_mult(input logic [UnitW-1:0] unit);
      logic [MultW-1:0] m;
      case (unit)
         UNIT_REVPS: m = MultRevps;
         UNIT_RADPS: m = MultRadps;
         default:    m = MultRpm;
      endcase
      return m;
   endfunction

   function automatic logic [TimerW-1:0] sat_inc(input logic [TimerW-1:0] v);
      return (v == {TimerW{1'b1}}) ? v : v + 1'b1;
   endfunction

endpackage

// ===== hw/rtl/apt_if.sv =====
// Request and response channel interfaces for the averaging-period tachometer.
// Depends on apt_pkg for field widths.
interface apt_req_if;
   logic       valid;
   logic       ready;
   logic       edge_req;
   logic       unit_button;
   logic       unit_write;
   logic [7:0] unit_value;

   modport source (output valid, edge_req, unit_button, unit_write, unit_value, input ready);
   modport sink   (input valid, edge_req, unit_button, unit_write, unit_value, output ready);
endinterface

interface apt_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      rate_valid;
   logic [apt_pkg::RateW-1:0] rate_milli;
   logic [apt_pkg::UnitW-1:0] unit_now;
   logic                      new_reading;
   logic                      display_blank;

   modport source (output valid, rate_valid, rate_milli, unit_now, new_reading, display_blank,
                   input ready);
   modport sink   (input valid, rate_valid, rate_milli, unit_now, new_reading, display_blank,
                   output ready);
endinterface

// ===== hw/rtl/apt_ctrl.sv =====
// Sequencing state machine of the tachometer: tick update, divide and beat issue.
// Depends on apt_pkg for the command and status structs.
module apt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  apt_pkg::status_type status,
   output apt_pkg::cmd_type    cmd
);

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_EVAL   = 7'b0000010,
      ST_INIT   = 7'b0000100,
      ST_DIV    = 7'b0001000,
      ST_STORE  = 7'b0010000,
      ST_FINISH = 7'b0100000,
      ST_SPARE  = 7'b1000000
   } state_type;

   state_type                   state_ff, state_in;
   logic [apt_pkg::DivCntW-1:0] step_ff, step_in;
   logic                        last_step;

   assign last_step = (step_ff == apt_pkg::DivCntW'(apt_pkg::DivSteps - 1));

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.tick = 1'b1;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.ops_load = 1'b1;
            state_in     = status.fresh ? ST_INIT : ST_FINISH;
         end
         ST_INIT: begin
            cmd.div_init = 1'b1;
            step_in      = '0;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (last_step) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.rev_store = 1'b1;
            state_in      = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

// ===== hw/rtl/apt_datapath.sv =====
// Datapath of the tachometer: config registers, timers, restoring divider, unit
// scaling and the response register. Depends on apt_pkg; driven by apt_ctrl.
module apt_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [apt_pkg::CsrIdxW-1:0]         csr_index,
   input  logic [apt_pkg::CfgWidth-1:0]        csr_wdata,
   input  logic                                edge_req,
   input  logic                                unit_button,
   input  logic                                unit_write,
   input  logic [7:0]                          unit_value,
   input  apt_pkg::cmd_type                    cmd,
   output apt_pkg::status_type                 status,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic                                rate_valid,
   output logic [apt_pkg::RateW-1:0]           rate_milli,
   output logic [apt_pkg::UnitW-1:0]           unit_now,
   output logic                                new_reading,
   output logic                                display_blank
);

   logic [apt_pkg::ConfSmallW-1:0] edges_avg_ff, slits_ff;
   logic [apt_pkg::TimerW-1:0]     timeout_ff, blank_ff;

   logic [apt_pkg::CountW-1:0] count_ff, count_in;
   logic [apt_pkg::TimerW-1:0] win_ff, win_in;
   logic [apt_pkg::TimerW-1:0] since_ff, since_in;
   logic                       have_ff, have_in;
   logic [apt_pkg::UnitW-1:0]  unit_ff, unit_in;
   logic                       fresh_ff, fresh_in;
   logic                       blank_flag_ff;
   logic [apt_pkg::RevW-1:0]   revps_ff;

   logic [apt_pkg::NumW-1:0]   num_ff;
   logic [apt_pkg::DenW-1:0]   den_ff;
   logic [apt_pkg::DenW-1:0]   rem_ff, rem_in;
   logic [apt_pkg::RevW-1:0]   quo_ff, quo_in;
   logic                       sat_ff;
   logic [apt_pkg::DenW:0]     trial;
   logic [apt_pkg::DenW:0]     trial_diff;
   logic                       trial_ge;
   logic [apt_pkg::DenW-1:0]   rem_start;

   logic [apt_pkg::ProdW-1:0]  rate_prod;

   logic                       rsp_valid_ff;
   logic                       rate_valid_ff;
   logic [apt_pkg::RateW-1:0]  rate_ff;
   logic [apt_pkg::UnitW-1:0]  unit_out_ff;
   logic                       new_reading_ff;
   logic                       blank_out_ff;

   // tick update
   always_comb begin
      since_in = apt_pkg::sat_inc(since_ff);
      win_in   = (count_ff != '0) ? apt_pkg::sat_inc(win_ff) : win_ff;
      count_in = count_ff;
      have_in  = have_ff;
      fresh_in = 1'b0;
      unit_in  = unit_ff;
      if (edge_req) begin
         if (count_ff == '0) begin
            win_in = '0;
         end
         count_in = count_ff + 1'b1;
         if (count_in > {1'b0, edges_avg_ff}) begin
            count_in = '0;
            since_in = '0;
            have_in  = 1'b1;
            fresh_in = 1'b1;
         end
      end
      if (since_in > timeout_ff) begin
         have_in = 1'b0;
      end
      if (unit_write) begin
         if (unit_value == apt_pkg::UNIT_CODE_REVPS) begin
            unit_in = apt_pkg::UNIT_REVPS;
         end else if (unit_value == apt_pkg::UNIT_CODE_RADPS) begin
            unit_in = apt_pkg::UNIT_RADPS;
         end else begin
            unit_in = apt_pkg::UNIT_RPM;
         end
      end
      if (unit_in == apt_pkg::UNIT_RADPS + 1'b1) begin
         unit_in = apt_pkg::UNIT_RPM;
      end
      if (unit_button) begin
         case (unit_in)
            apt_pkg::UNIT_RPM:   unit_in = apt_pkg::UNIT_REVPS;
            apt_pkg::UNIT_REVPS: unit_in = apt_pkg::UNIT_RADPS;
            default:             unit_in = apt_pkg::UNIT_RPM;
         endcase
      end
   end

   // restoring divider, one quotient bit a cycle
   assign rem_start  = {{(apt_pkg::DenW - 8){1'b0}}, num_ff[apt_pkg::NumW-1 -: 8]};
   assign trial      = {rem_ff, quo_ff[apt_pkg::RevW-1]};
   assign trial_diff = trial - {1'b0, den_ff};
   assign trial_ge   = (trial >= {1'b0, den_ff});

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (cmd.div_init) begin
         rem_in = rem_start;
         quo_in = num_ff[apt_pkg::RevW-1:0];
      end else if (cmd.div_step) begin
         rem_in = trial_ge ? trial_diff[apt_pkg::DenW-1:0] : trial[apt_pkg::DenW-1:0];
         quo_in = {quo_ff[apt_pkg::RevW-2:0], trial_ge};
      end
   end

   assign rate_prod = apt_pkg::ProdW'(revps_ff) * apt_pkg::ProdW'(apt_pkg::unit_mult(unit_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         edges_avg_ff  <= apt_pkg::EdgesAvgReset;
         slits_ff      <= apt_pkg::SlitsReset;
         timeout_ff    <= apt_pkg::TimeoutReset;
         blank_ff      <= apt_pkg::BlankReset;
         count_ff      <= '0;
         win_ff        <= '0;
         since_ff      <= '0;
         have_ff       <= 1'b0;
         unit_ff       <= apt_pkg::UNIT_RPM;
         fresh_ff      <= 1'b0;
         blank_flag_ff <= 1'b0;
         revps_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               apt_pkg::CSR_EDGES_AVG: edges_avg_ff <= csr_wdata[apt_pkg::ConfSmallW-1:0];
               apt_pkg::CSR_SLITS:     slits_ff     <= csr_wdata[apt_pkg::ConfSmallW-1:0];
               apt_pkg::CSR_TIMEOUT:   timeout_ff   <= csr_wdata;
               apt_pkg::CSR_BLANK:     blank_ff     <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.tick) begin
            count_ff      <= count_in;
            win_ff        <= win_in;
            since_ff      <= since_in;
            have_ff       <= have_in;
            unit_ff       <= unit_in;
            fresh_ff      <= fresh_in;
            blank_flag_ff <= (since_in > blank_ff);
         end
         if (cmd.rev_store) begin
            if (num_ff == '0) begin
               revps_ff <= '0;
            end else if (sat_ff) begin
               revps_ff <= apt_pkg::RevMax;
            end else begin
               revps_ff <= quo_ff;
            end
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (cmd.ops_load) begin
         num_ff <= apt_pkg::MicroScale * apt_pkg::NumW'(edges_avg_ff);
         den_ff <= apt_pkg::DenW'(win_ff) * apt_pkg::DenW'(slits_ff);
      end
      if (cmd.div_init) begin
         sat_ff <= (num_ff != '0) && (rem_start >= den_ff);
      end
      if (cmd.out_load) begin
         rate_valid_ff  <= have_ff;
         rate_ff        <= have_ff ? rate_prod[apt_pkg::QShift +: apt_pkg::RateW] : '0;
         unit_out_ff    <= unit_ff;
         new_reading_ff <= fresh_ff;
         blank_out_ff   <= blank_flag_ff;
      end
   end

   assign status.fresh    = fresh_ff;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rate_valid    = rate_valid_ff;
   assign rate_milli    = rate_ff;
   assign unit_now      = unit_out_ff;
   assign new_reading   = new_reading_ff;
   assign display_blank = blank_out_ff;

endmodule

// ===== hw/rtl/averaging_period_tachometer_core.sv =====
// Top level of the averaging-period tachometer: controller plus datapath.
// Depends on apt_pkg, apt_req_if, apt_rsp_if, apt_ctrl and apt_datapath.
//
// Usage: send one request beat per microsecond tick on req_chan carrying the
// edge flag and the unit controls. Each request produces exactly one response
// beat on rsp_chan with rate validity, rate in milli-units of the current unit,
// the unit, a new-reading flag and the display blank flag.
// Registers are written through csr_write_en / csr_index / csr_wdata: 0 edges
// averaged, 1 slits per revolution, 2 timeout, 3 blank. The user must write
// them only while the block is idle; the block does not enforce this itself.
// A tick that closes no window runs eval and finish; one that closes a window
// also runs init, the 40-step restoring divider (one quotient bit a cycle) and
// store. One request is in work at a time; the next is accepted after out_load.
// A finished response waits in the output register while the next request is
// accepted and worked on; that request stalls at its last step until the
// receiver takes the waiting beat.
// Reset (synchronous, active high) restores register defaults, clears counters,
// timers, the reading and the unit (rpm), and drops any pending response.
module averaging_period_tachometer_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_en,
   input  logic [apt_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [apt_pkg::CfgWidth-1:0] csr_wdata,
   apt_req_if.sink                      req_chan,
   apt_rsp_if.source                    rsp_chan
);

   apt_pkg::cmd_type    cmd;
   apt_pkg::status_type status;

   apt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   apt_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .edge_req      (req_chan.edge_req),
      .unit_button   (req_chan.unit_button),
      .unit_write    (req_chan.unit_write),
      .unit_value    (req_chan.unit_value),
      .cmd           (cmd),
      .status        (status),
      .rsp_ready     (rsp_chan.ready),
      .rsp_valid     (rsp_chan.valid),
      .rate_valid    (rsp_chan.rate_valid),
      .rate_milli    (rsp_chan.rate_milli),
      .unit_now      (rsp_chan.unit_now),
      .new_reading   (rsp_chan.new_reading),
      .display_blank (rsp_chan.display_blank)
   );

   assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("request accepted while a tick is still in work");

   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.new_reading |-> rsp_chan.rate_valid)
      else $error("new reading beat without a valid rate");

   assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid && req_chan.ready)
      else $error("block not idle after reset");

endmodule
